/* hdl/svpa_pkg.sv */
package svpa_pkg;

	localparam int unsigned PosW = 8;
	localparam int unsigned HoldW = 5;
	localparam int unsigned SettleW = 3;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned InDataW = 96;
	localparam int unsigned OutDataW = 16;

	localparam logic [PosW-1:0] LeftSetReset = 8'd120;
	localparam logic [PosW-1:0] LeftResetReset = 8'd200;
	localparam logic [PosW-1:0] RightSetReset = 8'd200;
	localparam logic [PosW-1:0] RightResetReset = 8'd120;

	localparam logic [HoldW-1:0] HoldShot = 5'd5;
	localparam logic [HoldW-1:0] HoldSwitch = 5'd10;
	localparam logic [HoldW-1:0] HoldKey = 5'd20;
	localparam logic [SettleW-1:0] SettleTicks = 3'd5;
	localparam logic [PosW-1:0] YawOffset = 8'd20;
	localparam logic signed [15:0] ShotMagLimit = 16'sd1000;
	localparam logic signed [10:0] StickDead = 11'sd10;
	localparam logic signed [15:0] MouseDead = 16'sd10;

	// Switch position codes.
	localparam logic [1:0] SwUp = 2'd0;
	localparam logic [1:0] SwMid = 2'd1;
	localparam logic [1:0] SwDown = 2'd2;

	// Key flag bit positions.
	localparam int unsigned KeyR = 0;
	localparam int unsigned KeyW = 1;
	localparam int unsigned KeyS = 2;
	localparam int unsigned KeyA = 3;
	localparam int unsigned KeyD = 4;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgLeftSet = 8'd0;
	localparam logic [CfgIdxW-1:0] CfgLeftReset = 8'd1;
	localparam logic [CfgIdxW-1:0] CfgRightSet = 8'd2;
	localparam logic [CfgIdxW-1:0] CfgRightReset = 8'd3;

	typedef struct packed {
		logic [PosW-1:0] left_set_pos;
		logic [PosW-1:0] left_reset_pos;
		logic [PosW-1:0] right_set_pos;
		logic [PosW-1:0] right_reset_pos;
	} svpa_cfg_t;

	typedef struct packed {
		logic signed [15:0] shot_speed_target;
		logic signed [15:0] shot_speed_meas;
		logic [1:0] switch_right;
		logic [1:0] switch_left;
		logic signed [10:0] stick_yaw;
		logic signed [10:0] stick_strafe;
		logic signed [10:0] stick_drive;
		logic signed [15:0] mouse_dx;
		logic [4:0] key_flags;
	} svpa_in_t;

	typedef struct packed {
		logic [HoldW-1:0] hold_count;
		logic sweep_dir;
		logic [SettleW-1:0] settle_count;
		logic [PosW-1:0] left_now;
		logic [PosW-1:0] right_now;
	} svpa_state_t;

endpackage

/* hdl/svpa_cfg.sv */
module svpa_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [svpa_pkg::CfgIdxW-1:0] cfg_index,
	input logic [svpa_pkg::PosW-1:0] cfg_data,
	output svpa_pkg::svpa_cfg_t cfg
);
	import svpa_pkg::*;

	svpa_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.left_set_pos <= LeftSetReset;
			regs_q.left_reset_pos <= LeftResetReset;
			regs_q.right_set_pos <= RightSetReset;
			regs_q.right_reset_pos <= RightResetReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgLeftSet: regs_q.left_set_pos <= cfg_data;
				CfgLeftReset: regs_q.left_reset_pos <= cfg_data;
				CfgRightSet: regs_q.right_set_pos <= cfg_data;
				CfgRightReset: regs_q.right_reset_pos <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

/* hdl/svpa_step.sv */
module svpa_step (
	input svpa_pkg::svpa_in_t item,
	input svpa_pkg::svpa_state_t st,
	input svpa_pkg::svpa_cfg_t cfg,
	output svpa_pkg::svpa_state_t nxt
);
	import svpa_pkg::*;

	logic [HoldW-1:0] hold;
	logic shot_active;
	logic yaw_right, yaw_left, fwd, back, strafe_a, strafe_d;
	logic [PosW:0] sum_l, sum_r;
	logic [PosW-1:0] mid_l, mid_r;
	logic [PosW-1:0] up_l, up_r, dn_l, dn_r;
	logic [PosW-1:0] s1_l, s1_r;
	logic flip0;

	always_comb begin
		hold = (st.hold_count != '0) ? st.hold_count - 1'b1 : '0;
		shot_active = (item.shot_speed_target != '0) &&
			((item.shot_speed_meas > ShotMagLimit) || (item.shot_speed_meas < -ShotMagLimit));
		if (shot_active) begin
			hold = HoldShot;
		end
		if (!(item.switch_left inside {SwUp, SwMid})) begin
			hold = HoldSwitch;
		end
		if (item.switch_right == SwDown || item.key_flags[KeyR]) begin
			hold = HoldKey;
		end

		yaw_right = (item.stick_yaw > StickDead) || (item.mouse_dx > MouseDead);
		yaw_left = (item.stick_yaw < -StickDead) || (item.mouse_dx < -MouseDead);
		fwd = (item.stick_drive > StickDead) || item.key_flags[KeyW];
		back = (item.stick_drive < -StickDead) || item.key_flags[KeyS];
		strafe_a = (item.stick_strafe > StickDead) || item.key_flags[KeyA];
		strafe_d = (item.stick_strafe < -StickDead) || item.key_flags[KeyD];

		sum_l = {1'b0, cfg.left_reset_pos} + {1'b0, cfg.left_set_pos};
		sum_r = {1'b0, cfg.right_reset_pos} + {1'b0, cfg.right_set_pos};
		mid_l = sum_l[PosW:1];
		mid_r = sum_r[PosW:1];

		// Step toward the reset pose; a bound on the wrong side is taken directly.
		up_l = (st.left_now < cfg.left_reset_pos) ? st.left_now + 1'b1 : cfg.left_reset_pos;
		up_r = (st.right_now > cfg.right_reset_pos) ? st.right_now - 1'b1 : cfg.right_reset_pos;
		flip0 = (up_l == cfg.left_reset_pos) && (up_r == cfg.right_reset_pos);

		// Step toward the set pose, from the current pose or from the turnaround.
		s1_l = st.sweep_dir ? st.left_now : up_l;
		s1_r = st.sweep_dir ? st.right_now : up_r;
		dn_l = (s1_l > cfg.left_set_pos) ? s1_l - 1'b1 : cfg.left_set_pos;
		dn_r = (s1_r < cfg.right_set_pos) ? s1_r + 1'b1 : cfg.right_set_pos;

		nxt = st;
		nxt.hold_count = hold;
		nxt.settle_count = SettleTicks;
		if (hold != '0) begin
			nxt.left_now = cfg.left_set_pos;
			nxt.right_now = cfg.right_set_pos;
			nxt.sweep_dir = 1'b0;
		end else if (yaw_right) begin
			nxt.left_now = cfg.left_reset_pos - YawOffset;
			nxt.right_now = cfg.right_set_pos - YawOffset;
			nxt.sweep_dir = 1'b0;
		end else if (yaw_left) begin
			nxt.left_now = cfg.left_set_pos + YawOffset;
			nxt.right_now = cfg.right_reset_pos + YawOffset;
			nxt.sweep_dir = 1'b1;
		end else if (fwd) begin
			nxt.left_now = cfg.left_set_pos;
			nxt.right_now = cfg.right_set_pos;
			nxt.sweep_dir = 1'b0;
		end else if (back) begin
			nxt.left_now = cfg.left_reset_pos;
			nxt.right_now = cfg.right_reset_pos;
			nxt.sweep_dir = 1'b1;
		end else if (strafe_a || strafe_d) begin
			nxt.left_now = mid_l;
			nxt.right_now = mid_r;
			nxt.sweep_dir = !strafe_a;
		end else if (st.settle_count != '0) begin
			nxt.left_now = mid_l;
			nxt.right_now = mid_r;
			nxt.settle_count = st.settle_count - 1'b1;
		end else begin
			nxt.settle_count = st.settle_count;
			if (!st.sweep_dir && !flip0) begin
				nxt.left_now = up_l;
				nxt.right_now = up_r;
				nxt.sweep_dir = 1'b0;
			end else begin
				nxt.left_now = dn_l;
				nxt.right_now = dn_r;
				nxt.sweep_dir = !((dn_l == cfg.left_set_pos) && (dn_r == cfg.right_set_pos));
			end
		end
	end

endmodule

/* hdl/servo_pose_animator.sv */
// Servo pose animator: each accepted item is one control tick and yields exactly one
// item with the left and right servo compare values. An item is registered on entry,
// evaluated combinationally against the hold/sweep state, and lands in the output
// register, so the block takes one item per clock unless both registers are full and
// m_tready is low; the output register lets a new item enter while a result waits.
// Pose registers are written through the cfg port (index 0..3; other indexes are
// ignored) and apply from the next item on; write them only when no item is in flight.
module servo_pose_animator (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// From bit 0: shot_speed_target[15:0], shot_speed_meas[31:16], switch_right[33:32],
	// switch_left[35:34], stick_yaw[46:36], stick_strafe[57:47], stick_drive[68:58],
	// mouse_dx[84:69], key_flags[89:85], zero fill [95:90].
	input logic [svpa_pkg::InDataW-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// From bit 0: left_pos[7:0], right_pos[15:8].
	output logic [svpa_pkg::OutDataW-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [svpa_pkg::CfgIdxW-1:0] cfg_index,
	input logic [svpa_pkg::PosW-1:0] cfg_data
);
	import svpa_pkg::*;

	svpa_cfg_t cfg;
	svpa_in_t item_in;
	svpa_in_t item_s1;
	logic valid_s1;
	svpa_state_t state_q;
	svpa_state_t state_nxt;
	logic out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	logic advance;

	assign cfg_ready = 1'b1;

	svpa_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	always_comb begin
		item_in.shot_speed_target = s_tdata[15:0];
		item_in.shot_speed_meas = s_tdata[31:16];
		item_in.switch_right = s_tdata[33:32];
		item_in.switch_left = s_tdata[35:34];
		item_in.stick_yaw = s_tdata[46:36];
		item_in.stick_strafe = s_tdata[57:47];
		item_in.stick_drive = s_tdata[68:58];
		item_in.mouse_dx = s_tdata[84:69];
		item_in.key_flags = s_tdata[89:85];
	end

	// The stage-1 item moves on whenever the output register is free or being emptied.
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	svpa_step u_step (
		.item(item_s1),
		.st(state_q),
		.cfg(cfg),
		.nxt(state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hold_count <= '0;
			state_q.sweep_dir <= 1'b1;
			state_q.settle_count <= SettleTicks;
			state_q.left_now <= LeftResetReset;
			state_q.right_now <= RightResetReset;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= {state_nxt.right_now, state_nxt.left_now};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled while the pipeline has room");

	a_state_still_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(state_q))
		else $error("tick state changed with no item in flight");

	a_key_hold_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && (item_s1.switch_right == SwDown || item_s1.key_flags[KeyR]))
		|=> (state_q.hold_count == HoldKey && !state_q.sweep_dir))
		else $error("hold not loaded for switch down or key R");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=>
		(m_tvalid && m_tdata == {state_q.right_now, state_q.left_now}))
		else $error("result differs from the stored servo positions");

endmodule

/* bench/tb_servo_pose_animator.sv */
`timescale 1ns / 100ps

module tb_servo_pose_animator;
	import svpa_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int PhaseTicks = 250;
	localparam int NumPhases = 8;
	localparam int MaxReports = 10;
	localparam logic [CfgIdxW-1:0] CfgFirstUnused = 8'd4;
	localparam logic [1:0] SwBad = 2'd3;

	typedef struct packed {
		logic [PosW-1:0] rpos;
		logic [PosW-1:0] lpos;
	} pose_t;

	typedef struct {
		svpa_in_t item;
		bit typed;
		pose_t pose;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [PosW-1:0] cfg_data = '0;

	// Shadow of the pose registers and of the animation state.
	svpa_cfg_t poses_cfg = '{LeftSetReset, LeftResetReset, RightSetReset, RightResetReset};
	logic [HoldW-1:0] hold_q = '0;
	logic dir_q = 1'b1;
	logic [SettleW-1:0] settle_q = SettleTicks;
	logic [PosW-1:0] left_q = LeftResetReset;
	logic [PosW-1:0] right_q = RightResetReset;

	pose_t pose_q[$];
	plan_row_t plan[$];
	svpa_in_t cur_tick = '0;
	bit typed_on = 1'b0;
	pose_t typed_pose = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int ticks_taken = 0;
	int poses_checked = 0;
	int cycle_cnt = 0;

	servo_pose_animator dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("Timeout after %0d cycles, %0d poses still pending", cycle_cnt,
				pose_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	function automatic void take_pose(input logic [PosW-1:0] l, input logic [PosW-1:0] r,
		input logic dir);
		left_q = l;
		right_q = r;
		dir_q = dir;
		settle_q = SettleTicks;
	endfunction

	// Advances the shadow state by one tick and returns the poses it shows.
	function automatic pose_t next_pose(input svpa_in_t t);
		int meas_mag, yaw, strafe, drive, mdx, nl, nr;
		int lset, lrst, rset, rrst;
		logic [PosW:0] sum_l, sum_r;
		logic [PosW-1:0] mid_l, mid_r;
		pose_t p;
		meas_mag = $signed(t.shot_speed_meas);
		if (meas_mag < 0)
			meas_mag = -meas_mag;
		yaw = $signed(t.stick_yaw);
		strafe = $signed(t.stick_strafe);
		drive = $signed(t.stick_drive);
		mdx = $signed(t.mouse_dx);
		lset = poses_cfg.left_set_pos;
		lrst = poses_cfg.left_reset_pos;
		rset = poses_cfg.right_set_pos;
		rrst = poses_cfg.right_reset_pos;
		sum_l = {1'b0, poses_cfg.left_reset_pos} + {1'b0, poses_cfg.left_set_pos};
		sum_r = {1'b0, poses_cfg.right_reset_pos} + {1'b0, poses_cfg.right_set_pos};
		mid_l = sum_l[PosW:1];
		mid_r = sum_r[PosW:1];

		// Later hold loads win over earlier ones.
		if (hold_q != 0)
			hold_q = hold_q - 1'b1;
		if (t.shot_speed_target != 0 && meas_mag > ShotMagLimit)
			hold_q = HoldShot;
		if (!(t.switch_left inside {SwUp, SwMid}))
			hold_q = HoldSwitch;
		if (t.switch_right == SwDown || t.key_flags[KeyR])
			hold_q = HoldKey;

		if (hold_q != 0) begin
			take_pose(poses_cfg.left_set_pos, poses_cfg.right_set_pos, 1'b0);
		end else if (yaw > StickDead || mdx > MouseDead) begin
			take_pose(poses_cfg.left_reset_pos - YawOffset,
				poses_cfg.right_set_pos - YawOffset, 1'b0);
		end else if (yaw < -StickDead || mdx < -MouseDead) begin
			take_pose(poses_cfg.left_set_pos + YawOffset,
				poses_cfg.right_reset_pos + YawOffset, 1'b1);
		end else if (drive > StickDead || t.key_flags[KeyW]) begin
			take_pose(poses_cfg.left_set_pos, poses_cfg.right_set_pos, 1'b0);
		end else if (drive < -StickDead || t.key_flags[KeyS]) begin
			take_pose(poses_cfg.left_reset_pos, poses_cfg.right_reset_pos, 1'b1);
		end else if (strafe > StickDead || t.key_flags[KeyA]) begin
			take_pose(mid_l, mid_r, 1'b0);
		end else if (strafe < -StickDead || t.key_flags[KeyD]) begin
			take_pose(mid_l, mid_r, 1'b1);
		end else if (settle_q != 0) begin
			left_q = mid_l;
			right_q = mid_r;
			settle_q = settle_q - 1'b1;
		end else begin
			// A flip toward the set pose also takes that step in the same tick.
			if (!dir_q) begin
				nl = left_q;
				nr = right_q;
				nl = nl + 1;
				nr = nr - 1;
				if (nl > lrst)
					nl = lrst;
				if (nr < rrst)
					nr = rrst;
				left_q = nl[PosW-1:0];
				right_q = nr[PosW-1:0];
				if (nl == lrst && nr == rrst)
					dir_q = 1'b1;
			end
			if (dir_q) begin
				nl = left_q;
				nr = right_q;
				nl = nl - 1;
				nr = nr + 1;
				if (nl < lset)
					nl = lset;
				if (nr > rset)
					nr = rset;
				left_q = nl[PosW-1:0];
				right_q = nr[PosW-1:0];
				if (nl == lset && nr == rset)
					dir_q = 1'b0;
			end
		end
		p.lpos = left_q;
		p.rpos = right_q;
		return p;
	endfunction

	function automatic void check_field(input string fld, input logic [PosW-1:0] want,
		input logic [PosW-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MaxReports)
				$display("%0t: pose %0d %s expected %0d, got %0d", $time, poses_checked,
					fld, want, got);
		end
	endfunction

	// Results are checked before the new tick is predicted, so the order within the
	// edge is fixed.
	always @(posedge clk) begin
		pose_t got;
		pose_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pose_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports)
						$display("%0t: unexpected item %0d/%0d with nothing pending",
							$time, got.lpos, got.rpos);
				end else begin
					want = pose_q.pop_front();
					check_field("left_pos", want.lpos, got.lpos);
					check_field("right_pos", want.rpos, got.rpos);
					poses_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = next_pose(cur_tick);
				pose_q.push_back(typed_on ? typed_pose : want);
				ticks_taken++;
			end
		end
	end

	function automatic svpa_in_t mk(input int tgt, input int meas, input int swr,
		input int swl, input int yaw, input int strafe, input int drive, input int mdx,
		input int keys);
		svpa_in_t t;
		t.shot_speed_target = 16'(tgt);
		t.shot_speed_meas = 16'(meas);
		t.switch_right = 2'(swr);
		t.switch_left = 2'(swl);
		t.stick_yaw = 11'(yaw);
		t.stick_strafe = 11'(strafe);
		t.stick_drive = 11'(drive);
		t.mouse_dx = 16'(mdx);
		t.key_flags = 5'(keys);
		return t;
	endfunction

	function automatic void add_row(input svpa_in_t it, input bit typed, input int l = 0,
		input int r = 0);
		plan_row_t row;
		row.item = it;
		row.typed = typed;
		row.pose.lpos = PosW'(l);
		row.pose.rpos = PosW'(r);
		plan.push_back(row);
	endfunction

	// A tick that touches nothing: sticks in the dead band, shooter idle, no keys.
	function automatic svpa_in_t rand_quiet();
		int meas;
		meas = $urandom_range(2000);
		meas = meas - 1000;
		if ($urandom_range(3) == 0)
			return mk(0, $urandom, $urandom_range(1), $urandom_range(1),
				$urandom_range(20) - 10, $urandom_range(20) - 10, $urandom_range(20) - 10,
				$urandom_range(20) - 10, 0);
		return mk($urandom, meas, $urandom_range(1), $urandom_range(1),
			$urandom_range(20) - 10, $urandom_range(20) - 10, $urandom_range(20) - 10,
			$urandom_range(20) - 10, 0);
	endfunction

	function automatic svpa_in_t rand_event();
		svpa_in_t t;
		int edge_val;
		t = rand_quiet();
		edge_val = $urandom_range(1) ? 10 + $urandom_range(1) : -10 - $urandom_range(1);
		case ($urandom_range(8))
			0: t.stick_yaw = 11'($urandom);
			1: t.stick_strafe = 11'($urandom);
			2: t.stick_drive = 11'($urandom);
			3: t.mouse_dx = 16'($urandom);
			4: t.key_flags = 5'($urandom);
			5: begin
				t.shot_speed_target = 16'($urandom);
				t.shot_speed_meas = 16'($urandom_range(1) ? $urandom :
					$urandom_range(1100) - 550);
			end
			6: begin
				t.switch_right = 2'($urandom);
				t.switch_left = 2'($urandom);
			end
			7: case ($urandom_range(3))
				0: t.stick_yaw = 11'(edge_val);
				1: t.stick_strafe = 11'(edge_val);
				2: t.stick_drive = 11'(edge_val);
				default: t.mouse_dx = 16'(edge_val);
			endcase
			default: t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		endcase
		return t;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_tick(input svpa_in_t it, input bit typed, input pose_t pose);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {6'b0, it.key_flags, it.mouse_dx, it.stick_drive, it.stick_strafe,
			it.stick_yaw, it.switch_left, it.switch_right, it.shot_speed_meas,
			it.shot_speed_target};
		s_tvalid <= 1'b1;
		cur_tick = it;
		typed_on = typed;
		typed_pose = pose;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CfgLeftSet: poses_cfg.left_set_pos = val;
			CfgLeftReset: poses_cfg.left_reset_pos = val;
			CfgRightSet: poses_cfg.right_set_pos = val;
			CfgRightReset: poses_cfg.right_reset_pos = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Holds the input back until every pose in flight has come out.
	task automatic drain_poses();
		s_tvalid <= 1'b0;
		while (pose_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int gap_by_mode[4] = '{0, 59, 0, 35};
		int stall_by_mode[4] = '{0, 0, 59, 35};
		int sent, run_len;
		bit quiet_run;
		logic [PosW-1:0] ls, lr, rs, rr;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks against the power-up poses 120/200 and 200/120.
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 0), 1, 160, 160);
		add_row(mk(0, 0, SwUp, SwUp, 1023, 0, 0, 0, 0), 1, 180, 180);
		add_row(mk(0, 0, SwUp, SwUp, -1024, 0, 0, 0, 0), 1, 140, 140);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 32767, 0), 1, 180, 180);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, -32768, 0), 1, 140, 140);
		add_row(mk(0, 0, SwUp, SwMid, 0, 0, 1023, 0, 0), 1, 120, 200);
		add_row(mk(0, 0, SwMid, SwUp, 0, 0, -1024, 0, 0), 1, 200, 120);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 1 << KeyW), 1, 120, 200);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 1 << KeyS), 1, 200, 120);
		add_row(mk(0, 0, SwUp, SwUp, 0, 1023, 0, 0, 0), 1, 160, 160);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 1 << KeyD), 1, 160, 160);
		add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 1 << KeyA), 1, 160, 160);
		add_row(mk(0, 0, SwUp, SwUp, 0, -1024, 0, 0, 0), 1, 160, 160);
		// Yaw and mouse right at the dead band edge fall through to drive.
		add_row(mk(0, 0, SwUp, SwUp, 10, 0, 11, -10, 0), 1, 120, 200);
		// Five settle ticks at the midpoint, then the first sweep step.
		repeat (6) add_row(mk(0, 0, SwUp, SwUp, 0, 0, 0, 0, 0), 0);
		add_row(mk(1, -32768, SwUp, SwUp, 0, 0, 0, 0, 0), 1, 120, 200);
		add_row(mk(0, 32767, SwUp, SwUp, -10, 10, -10, 10, 0), 0);
		add_row(mk(0, 0, SwUp, SwBad, 0, 0, 0, 0, 0), 0);
		add_row(mk(0, 0, SwBad, SwUp, 0, 0, 0, 0, 0), 0);
		add_row(mk(0, 0, SwDown, SwDown, 0, 0, 0, 0, 0), 0);
		add_row(mk(-32768, 1001, SwUp, SwUp, 0, 0, 0, 0, 5'h1F), 0);
		add_row(mk(32767, 1000, SwMid, SwMid, 1023, 1023, 1023, 32767, 0), 0);

		foreach (plan[i])
			send_tick(plan[i].item, plan[i].typed, plan[i].pose);
		drain_poses();

		for (int ph = 0; ph < NumPhases; ph++) begin
			gap_pct = gap_by_mode[ph % 4];
			stall_pct = stall_by_mode[ph % 4];
			case (ph)
				0: begin ls = 8'd0; lr = 8'd255; rs = 8'd255; rr = 8'd0; end
				1: begin ls = 8'd255; lr = 8'd0; rs = 8'd0; rr = 8'd255; end
				2: begin ls = 8'd0; lr = 8'd0; rs = 8'd0; rr = 8'd0; end
				3: begin ls = 8'd255; lr = 8'd255; rs = 8'd255; rr = 8'd255; end
				default: begin
					// Close poses so the sweep turns around often.
					ls = PosW'($urandom);
					lr = PosW'(ls + $urandom_range(12) - 6);
					rs = PosW'($urandom);
					rr = PosW'(rs + $urandom_range(12) - 6);
				end
			endcase
			write_reg(CfgLeftSet, ls);
			write_reg(CfgLeftReset, lr);
			write_reg(CfgRightSet, rs);
			write_reg(CfgRightReset, rr);
			write_reg(CfgIdxW'($urandom_range(255, CfgFirstUnused)), PosW'($urandom));
			cfg_valid <= 1'b0;
			@(negedge clk);

			sent = 0;
			while (sent < PhaseTicks) begin
				if ($urandom_range(39) == 0)
					drain_poses();
				quiet_run = $urandom_range(99) < 45;
				run_len = quiet_run ? $urandom_range(80, 5) : $urandom_range(4, 1);
				if (run_len > PhaseTicks - sent)
					run_len = PhaseTicks - sent;
				repeat (run_len)
					send_tick(quiet_run ? rand_quiet() : rand_event(), 1'b0, '0);
				sent += run_len;
			end
			drain_poses();
		end

		$display("Covered %0d ticks and %0d checked poses over %0d pose settings,", ticks_taken,
			poses_checked, NumPhases + 1);
		$display("including the 0 and 255 extremes, with four mixes of input gaps and stalls.");
		if (mismatch_count == 0 && pose_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
